FILE: rtl/hk_pkg.sv
// shared types and constants for the subset dynamic program tour solver
`default_nettype none
package hk_pkg;

  localparam int COST_W = 20;
  localparam int CITY_W = 4;
  localparam int POS_W  = 4;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  // register index decoded from paddr[2]
  localparam logic IDX_NUM_CITIES = 1'b0;

  // one entry of the cost table
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [CITY_W-1:0] nxt;
  } tbl_entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SWEEP = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_RD    = 6'b001000,
    ST_LD    = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/hk_dist_store.sv
// distance matrix memory plus a register copy of the column back to city 0
`default_nettype none
module hk_dist_store #(
  parameter int MAX_CITIES = 12,
  parameter int DW         = 16,
  parameter int CIW        = 4
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [CIW-1:0] wr_row,
  input  wire logic [CIW-1:0] wr_col,
  input  wire logic [DW-1:0]  wr_data,
  input  wire logic [CIW-1:0] rd_row,
  input  wire logic [CIW-1:0] rd_col,
  output logic      [DW-1:0]  rd_data,
  input  wire logic [CIW-1:0] col_sel,
  output logic      [DW-1:0]  col_data,
  output logic      [DW-1:0]  col_first
);

  logic [DW-1:0] mem [2**(2*CIW)];
  logic [DW-1:0] col0 [MAX_CITIES];

  // matrix write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_row, wr_col}] <= wr_data;
    end
    rd_data <= mem[{rd_row, rd_col}];
  end

  // column zero copy, used when the visited set is complete
  always_ff @(posedge clk) begin
    if (wr_en && wr_col == '0) begin
      col0[wr_row] <= wr_data;
    end
  end

  assign col_data  = col0[col_sel];
  assign col_first = col0[0];

endmodule
`default_nettype wire

FILE: rtl/hk_table_mem.sv
// cost and next-city table, one write and one registered read per cycle
`default_nettype none
module hk_table_mem
  import hk_pkg::*;
#(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire tbl_entry_t    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output tbl_entry_t         rd_data
);

  tbl_entry_t mem [2**AW];

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/held_karp_tsp_solver_top.sv
// Shortest closed tour solver over an asymmetric distance matrix. A load beat
// (action 0) writes one matrix entry. A solve beat (action 1) sweeps the
// subset table bottom-up: for n cities it visits every odd visited set short
// of the full one, every city and every candidate next city, one candidate a
// cycle, and then passes through a drain state for the pipeline. The tour
// comes out as n+1 beats, city 0 first and last; each of the first n passes
// through a table read, a load and an output state, and the closing beat
// follows in the cycle after the beat before it is taken. One city skips the
// sweep; zero cities gives a single error beat. No input beat is taken until
// the last result beat has been taken. Memories have no reset and need no
// clearing pass.
`default_nettype none
module held_karp_tsp_solver_top
  import hk_pkg::*;
#(
  parameter int MAX_CITIES = 12,
  parameter int DIST_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              action,
  input  wire logic [3:0]        from_city,
  input  wire logic [3:0]        to_city,
  input  wire logic [15:0]       distance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       position,
  output logic [CITY_W-1:0]      city,
  output logic [COST_W-1:0]      tour_length,
  output logic                   is_error,
  output logic                   last
);

  localparam int CIW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int NW  = $clog2(MAX_CITIES + 1);
  localparam int DW  = (DIST_BITS < 16) ? DIST_BITS : 16;
  localparam int TAW = CIW + MAX_CITIES;

  state_t state;

  logic [3:0] num_cities;
  logic [NW-1:0] n_eff, n_q;
  logic [CIW-1:0] n_last;
  logic [MAX_CITIES-1:0] full_eff, full_q;

  // sweep counters
  logic [MAX_CITIES-1:0] sw_set, sw_m, sw_setm;
  logic [CIW-1:0] sw_c, sw_i;

  // pipeline stage after the memory reads
  logic p_v, p_first, p_last, p_cin, p_cand, p_full;
  logic [CIW-1:0] p_i, p_c;
  logic [MAX_CITIES-1:0] p_set;

  // running minimum
  logic [COST_W-1:0] acc, best_val, d_sat, cost_in;
  logic [COST_W:0] d_sum;
  logic [CIW-1:0] acc_i, best_idx;
  logic acc_ok, acc_ok_eff, take;

  // tour walk
  logic [CIW-1:0] t_city, nxt_fix;
  logic [MAX_CITIES-1:0] t_set;
  logic [NW-1:0] k;
  logic [COST_W-1:0] len_q, len_v;

  // memory ports
  logic dist_we;
  logic [DW-1:0] dist_rd, col_data, col_first;
  logic tbl_we;
  logic [TAW-1:0] tbl_wa, tbl_ra;
  tbl_entry_t tbl_wd, tbl_rd;

  logic in_fire, out_fire, cfg_we;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == IDX_NUM_CITIES);
  assign prdata = (paddr[2] == IDX_NUM_CITIES) ? 32'(num_cities) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cities <= '0;
    end else if (cfg_we) begin
      num_cities <= pwdata[3:0];
    end
  end

  // city count limit and full-set masks
  assign n_eff  = (num_cities > MAX_CITIES) ? NW'(MAX_CITIES) : NW'(num_cities);
  assign n_last = CIW'(n_q - NW'(1));

  always_comb begin
    for (int j = 0; j < MAX_CITIES; j++) begin
      full_eff[j] = (j < n_eff);
      full_q[j]   = (j < n_q);
    end
  end

  // handshakes
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // distance loads
  assign dist_we = in_fire && (action == ACT_LOAD) &&
                   (from_city < MAX_CITIES) && (to_city < MAX_CITIES);

  hk_dist_store #(
    .MAX_CITIES (MAX_CITIES),
    .DW         (DW),
    .CIW        (CIW)
  ) u_dist (
    .clk       (clk),
    .wr_en     (dist_we),
    .wr_row    (from_city[CIW-1:0]),
    .wr_col    (to_city[CIW-1:0]),
    .wr_data   (distance[DW-1:0]),
    .rd_row    (sw_c),
    .rd_col    (sw_i),
    .rd_data   (dist_rd),
    .col_sel   (p_i),
    .col_data  (col_data),
    .col_first (col_first)
  );

  // read addresses; for a candidate city the sweep reads a strict superset of the set being written
  assign sw_m    = MAX_CITIES'(1) << sw_i;
  assign sw_setm = sw_set | sw_m;
  assign tbl_ra  = (state == ST_SWEEP) ? {sw_i, sw_setm} : {t_city, t_set};

  hk_table_mem #(
    .AW (TAW)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_wa),
    .wr_data (tbl_wd),
    .rd_addr (tbl_ra),
    .rd_data (tbl_rd)
  );

  // stage registers are registered alongside the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= (state == ST_SWEEP);
    end
    p_first <= (sw_i == '0);
    p_last  <= (sw_i == n_last);
    p_cin   <= sw_set[sw_c];
    p_cand  <= sw_set[sw_c] && !sw_set[sw_i];
    p_full  <= (sw_setm == full_q);
    p_i     <= sw_i;
    p_c     <= sw_c;
    p_set   <= sw_set;
  end

  // candidate cost with saturation, then strict-less compare keeps lowest index
  always_comb begin
    cost_in    = p_full ? COST_W'(col_data) : tbl_rd.cost;
    d_sum      = (COST_W+1)'(dist_rd) + (COST_W+1)'(cost_in);
    d_sat      = d_sum[COST_W] ? COST_MAX : d_sum[COST_W-1:0];
    acc_ok_eff = p_first ? 1'b0 : acc_ok;
    take       = p_cand && (!acc_ok_eff || (d_sat < acc));
    best_val   = take ? d_sat : acc;
    best_idx   = take ? p_i : acc_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_ok <= 1'b0;
    end else if (p_v) begin
      acc_ok <= acc_ok_eff || p_cand;
    end
    if (p_v) begin
      acc   <= best_val;
      acc_i <= best_idx;
    end
  end

  // write back once every candidate of a city has been seen
  assign tbl_we      = p_v && p_last && p_cin;
  assign tbl_wa      = {p_c, p_set};
  assign tbl_wd.cost = best_val;
  assign tbl_wd.nxt  = CITY_W'(best_idx);

  // tour step from the table entry just read
  always_comb begin
    nxt_fix = (tbl_rd.nxt >= n_q) ? '0 : tbl_rd.nxt[CIW-1:0];
    if (k == '0) begin
      len_v = (n_q == NW'(1)) ? COST_W'(col_first) : tbl_rd.cost;
    end else begin
      len_v = len_q;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && action == ACT_SOLVE) begin
            n_q    <= n_eff;
            t_city <= '0;
            t_set  <= MAX_CITIES'(1);
            k      <= '0;
            sw_set <= full_eff - MAX_CITIES'(2);
            sw_c   <= '0;
            sw_i   <= '0;
            if (n_eff == '0) begin
              position    <= '0;
              city        <= '0;
              tour_length <= '0;
              is_error    <= 1'b1;
              last        <= 1'b1;
              out_valid   <= 1'b1;
              state       <= ST_OUT;
            end else if (n_eff == NW'(1)) begin
              state <= ST_RD;
            end else begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (sw_i == n_last) begin
            sw_i <= '0;
            if (sw_c == n_last) begin
              sw_c <= '0;
              if (sw_set == MAX_CITIES'(1)) begin
                state <= ST_DRAIN;
              end else begin
                sw_set <= sw_set - MAX_CITIES'(2);
              end
            end else begin
              sw_c <= sw_c + CIW'(1);
            end
          end else begin
            sw_i <= sw_i + CIW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_LD;
        end
        ST_LD: begin
          position    <= POS_W'(k);
          city        <= CITY_W'(t_city);
          tour_length <= len_v;
          is_error    <= 1'b0;
          last        <= 1'b0;
          out_valid   <= 1'b1;
          len_q       <= len_v;
          t_city      <= nxt_fix;
          t_set       <= t_set | (MAX_CITIES'(1) << nxt_fix);
          k           <= k + NW'(1);
          state       <= ST_OUT;
        end
        ST_OUT: begin
          if (out_fire) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= ST_IDLE;
            end else if (k == n_q) begin
              position <= POS_W'(k);
              city     <= '0;
              last     <= 1'b1;
            end else begin
              out_valid <= 1'b0;
              state     <= ST_RD;
            end
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hk_checker.sv
// port-level checks on the tour solver and their bind to the top level
`default_nettype none
module hk_checker
  import hk_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [POS_W-1:0]  position,
  input wire logic [CITY_W-1:0] city,
  input wire logic [COST_W-1:0] tour_length,
  input wire logic              is_error,
  input wire logic              last
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(city) &&
    $stable(tour_length) && $stable(is_error) && $stable(last))
    else $error("result beat changed while stalled");

  // no input taken while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // error beat is a lone all-zero beat
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_error |-> last && position == '0 && city == '0 && tour_length == '0)
    else $error("malformed error beat");

  // the tour closes at city 0
  a_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !is_error |-> city == '0)
    else $error("tour does not return to city 0");

  // a beat still valid right after a taken non-last beat keeps the tour length
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid || $stable(tour_length))
    else $error("tour length changed within a tour");

endmodule

bind held_karp_tsp_solver_top hk_checker u_hk_checker (.*);
`default_nettype wire
